// ----- src/lsd_pkg.sv -----
// Shared types and constants for the LOAS sync deframer.
package lsd_pkg;

  localparam logic [7:0] SYNC_BYTE     = 8'h56;
  localparam logic [7:0] SECOND_MASK   = 8'hE0;
  localparam int         LEN_W         = 13;
  localparam int         LEN_HIGH_W    = LEN_W - 8;

  localparam int         QUEUE_DEPTH   = 4;
  localparam int         QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int         QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    ENTRY_HEADER  = 1'b0,
    ENTRY_PAYLOAD = 1'b1
  } entry_kind_t;

  // One queued request: a whole valid header or one payload byte.
  typedef struct packed {
    entry_kind_t kind;
    logic [7:0]  byte_a;   // second header byte (header only)
    logic [7:0]  byte_b;   // third header byte, or the payload byte
    logic        last;     // final payload byte of the frame
  } entry_t;

  typedef enum logic [3:0] {
    PHASE_HUNT    = 4'b0001,
    PHASE_SYNC    = 4'b0010,
    PHASE_SECOND  = 4'b0100,
    PHASE_PAYLOAD = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    BEAT_SYNC   = 3'b001,
    BEAT_SECOND = 3'b010,
    BEAT_THIRD  = 3'b100
  } beat_t;

endpackage

// ----- src/loas_sync_deframer_top.sv -----
// Top level of the LOAS sync deframer: parser, request queue and output sequencer.
//
// Input channel: one raw stream byte per request on data_byte, moved when
// in_valid is high and in_stall is low. Output channel: one frame byte per
// request on frame_byte with frame_first (first header byte, 0x56) and
// frame_last (final payload byte), moved when out_valid is high and
// out_stall is low. Bytes outside a valid frame are dropped.
// A payload byte passes through the request queue and then the output
// register, where it waits until out_stall is low.
// The third header byte releases all three header bytes, which leave
// the output register in order, sync byte first.
// Throughput: one input byte per cycle while the queue has room, one output
// byte per cycle while out_stall is low. A header yields three output bytes;
// the two preceding header bytes produce nothing, so the average holds.
// A four-entry request queue separates the parser from the output register;
// in_stall rises only when that queue is full.
// Reset (rst, synchronous): the parser returns to hunting for a sync byte,
// the queue empties and out_valid drops. When the receiver stalls, the
// output register holds its byte, the queue fills, then the input stalls.
module loas_sync_deframer_top import lsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] frame_byte,
  output logic       frame_first,
  output logic       frame_last
);

  // Parser to queue.
  logic   push;
  entry_t push_entry;
  logic   q_full;

  // Queue to sequencer.
  entry_t head;
  logic   q_not_empty;
  logic   pop;

  // Hunt for sync, check length, classify each byte into a request.
  lsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Hold requests so that each side can stall on its own.
  lsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (q_not_empty),
    .full       (q_full)
  );

  // Expand header requests into three bytes, pass payload bytes, register output.
  lsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_not_empty (q_not_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_byte  (frame_byte),
    .frame_first (frame_first),
    .frame_last  (frame_last)
  );

endmodule

// ----- src/lsd_front.sv -----
// Front end: header parser that classifies each input byte into a queue request.
module lsd_front import lsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       q_full,
  output logic       push,
  output entry_t     push_entry
);

  phase_t             phase, phase_next;
  logic [7:0]         second_byte, second_byte_next;
  logic [LEN_W-1:0]   remaining, remaining_next;
  logic [LEN_W-1:0]   frame_len;
  logic               accept;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign frame_len = {second_byte[LEN_HIGH_W-1:0], data_byte};

  always_comb begin
    phase_next        = phase;
    second_byte_next  = second_byte;
    remaining_next    = remaining;
    push              = 1'b0;
    push_entry.kind   = ENTRY_PAYLOAD;
    push_entry.byte_a = second_byte;
    push_entry.byte_b = data_byte;
    push_entry.last   = 1'b0;
    if (accept) begin
      unique case (phase)
        PHASE_HUNT: begin
          if (data_byte == SYNC_BYTE) phase_next = PHASE_SYNC;
        end
        PHASE_SYNC: begin
          if ((data_byte & SECOND_MASK) == SECOND_MASK) begin
            second_byte_next = data_byte;
            phase_next       = PHASE_SECOND;
          end else if (data_byte != SYNC_BYTE) begin
            phase_next = PHASE_HUNT;
          end
        end
        PHASE_SECOND: begin
          if (frame_len == '0) begin
            phase_next = PHASE_HUNT;
          end else begin
            push            = 1'b1;
            push_entry.kind = ENTRY_HEADER;
            remaining_next  = frame_len;
            phase_next      = PHASE_PAYLOAD;
          end
        end
        PHASE_PAYLOAD: begin
          if (remaining == '0) begin
            phase_next = PHASE_HUNT;
          end else begin
            push            = 1'b1;
            push_entry.last = (remaining == LEN_W'(1));
            remaining_next  = remaining - LEN_W'(1);
            if (remaining == LEN_W'(1)) phase_next = PHASE_HUNT;
          end
        end
        default: phase_next = PHASE_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PHASE_HUNT;
      second_byte <= '0;
      remaining   <= '0;
    end else begin
      phase       <= phase_next;
      second_byte <= second_byte_next;
      remaining   <= remaining_next;
    end
  end

endmodule

// ----- src/lsd_queue.sv -----
// Short request queue between the parser and the output sequencer.
module lsd_queue import lsd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   not_empty,
  output logic   full
);

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign not_empty = (count != '0);
  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      priority if (push && !pop) count <= count + QCNT_W'(1);
      else if (pop && !push)     count <= count - QCNT_W'(1);
    end
  end

endmodule

// ----- src/lsd_back.sv -----
// Back end: expands queued requests into output bytes through an output register.
module lsd_back import lsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  entry_t     head,
  input  logic       q_not_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] frame_byte,
  output logic       frame_first,
  output logic       frame_last
);

  beat_t      beat, beat_next;
  logic       can_load, load;
  logic [7:0] byte_next;
  logic       first_next, last_next;

  assign can_load = !out_valid || !out_stall;
  assign load     = can_load && q_not_empty;

  always_comb begin
    beat_next  = beat;
    pop        = 1'b0;
    byte_next  = head.byte_b;
    first_next = 1'b0;
    last_next  = 1'b0;
    if (load) begin
      if (head.kind == ENTRY_PAYLOAD) begin
        last_next = head.last;
        pop       = 1'b1;
      end else begin
        unique case (beat)
          BEAT_SYNC: begin
            byte_next  = SYNC_BYTE;
            first_next = 1'b1;
            beat_next  = BEAT_SECOND;
          end
          BEAT_SECOND: begin
            byte_next = head.byte_a;
            beat_next = BEAT_THIRD;
          end
          BEAT_THIRD: begin
            pop       = 1'b1;
            beat_next = BEAT_SYNC;
          end
          default: beat_next = BEAT_SYNC;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat      <= BEAT_SYNC;
    end else begin
      if (can_load) out_valid <= q_not_empty;
      beat <= beat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_byte  <= byte_next;
      frame_first <= first_next;
      frame_last  <= last_next;
    end
  end

endmodule

// ----- verif/loas_sync_deframer_top_tb.sv -----
// Self-checking testbench for the LOAS sync deframer top level.
module loas_sync_deframer_top_tb import lsd_pkg::*;;

  // Bounds of the run. The limit is a few times the slowest legal run: about
  // 500 requests, each with the longest sender gap and three results each
  // waiting out the longest receiver stall, plus the long receiver hold.
  localparam int RANDOM_ITEMS = 460;
  localparam int CYCLE_LIMIT  = 100_000;
  localparam int LONG_HOLD    = 40;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_PRINTED  = 50;

  // Stimulus queue entries: a data byte, or a marker that steers the sender.
  typedef enum logic [1:0] {
    ITEM_BYTE,     // one request on data_byte
    ITEM_RX_HOLD,  // ask the receiver for one long stall
    ITEM_DRAIN,    // stop sending until every expected byte is out
    ITEM_CALM      // turn off random idling on both sides from here on
  } item_kind_t;

  typedef struct {
    item_kind_t kind;
    logic [7:0] value;
  } stim_item_t;

  // One expected output request.
  typedef struct {
    logic [7:0] value;
    logic       first;
    logic       last;
  } frame_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] frame_byte;
  logic       frame_first;
  logic       frame_last;

  stim_item_t  pending_bytes[$];
  frame_beat_t expected_frame_bytes[$];

  // Deframer prediction state.
  phase_t           parse_state    = PHASE_HUNT;
  logic [7:0]       length_hi_byte = 8'h00;
  logic [LEN_W-1:0] payload_left   = '0;

  // Handshake bookkeeping shared between sender, receiver and checker.
  logic byte_taken = 1'b0;
  logic calm_tail  = 1'b0;
  int   rx_hold_requests = 0;
  int   rx_holds_served  = 0;
  int   mismatch_count   = 0;
  int   cycle_count      = 0;

  // Sender and receiver idling state.
  int   send_gap  = 0;
  int   send_seg  = 0;
  logic send_busy = 1'b0;
  int   stall_left = 0;
  int   hold_left  = 0;
  int   recv_seg   = 0;
  logic recv_busy  = 1'b0;

  loas_sync_deframer_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_byte (frame_byte),
    .frame_first(frame_first),
    .frame_last (frame_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
    end
  endtask

  // Append one expected frame byte.
  function automatic void expect_beat(input logic [7:0] value, input logic is_first,
                                      input logic is_last);
    expected_frame_bytes.insert(expected_frame_bytes.size(),
                                frame_beat_t'{value, is_first, is_last});
  endfunction

  // Advance the deframer prediction by one accepted byte and queue the
  // frame bytes it releases.
  function automatic void deframe_byte(input logic [7:0] b);
    logic [LEN_W-1:0] frame_len;
    frame_len = {length_hi_byte[LEN_HIGH_W-1:0], b};
    case (parse_state)
      PHASE_HUNT: begin
        if (b == SYNC_BYTE) parse_state = PHASE_SYNC;
      end
      PHASE_SYNC: begin
        // A repeated sync byte keeps us waiting for the second header byte.
        if ((b & SECOND_MASK) == SECOND_MASK) begin
          length_hi_byte = b;
          parse_state = PHASE_SECOND;
        end else if (b != SYNC_BYTE) begin
          parse_state = PHASE_HUNT;
        end
      end
      PHASE_SECOND: begin
        // Zero length is a false sync: drop the whole header, no restart inside it.
        if (frame_len == '0) begin
          parse_state = PHASE_HUNT;
        end else begin
          expect_beat(SYNC_BYTE, 1'b1, 1'b0);
          expect_beat(length_hi_byte, 1'b0, 1'b0);
          expect_beat(b, 1'b0, 1'b0);
          payload_left = frame_len;
          parse_state = PHASE_PAYLOAD;
        end
      end
      default: begin
        // Payload bytes pass untouched, sync bytes included.
        if (payload_left == '0) begin
          parse_state = PHASE_HUNT;
        end else begin
          expect_beat(b, 1'b0, payload_left == 1);
          payload_left = payload_left - 1'b1;
          if (payload_left == '0) parse_state = PHASE_HUNT;
        end
      end
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.insert(pending_bytes.size(), stim_item_t'{ITEM_BYTE, b});
  endtask

  task automatic push_marker(input item_kind_t kind);
    pending_bytes.insert(pending_bytes.size(), stim_item_t'{kind, 8'h00});
  endtask

  // Queue a well-formed frame with random payload; sync bytes are seeded
  // into the payload now and then.
  task automatic push_frame(input logic [LEN_W-1:0] frame_len, input bit twin_sync);
    if (twin_sync) push_byte(SYNC_BYTE);
    push_byte(SYNC_BYTE);
    push_byte(SECOND_MASK | {3'b000, frame_len[LEN_W-1:8]});
    push_byte(frame_len[7:0]);
    for (int i = 0; i < frame_len; i++) begin
      if ($urandom_range(0, 15) == 0) push_byte(SYNC_BYTE);
      else push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Record each request taken by the block and predict what it releases.
  always @(posedge clk) begin : intake
    byte_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      deframe_byte(data_byte);
      void'(pending_bytes.pop_front());
    end
  end

  // Sender: offer the head of the stimulus queue, hold it while stalled,
  // and idle in random bursts during busy stretches.
  always @(negedge clk) begin : sender
    logic offer;
    offer = 1'b0;
    if (!rst && in_valid && !byte_taken) begin
      // Hold the stalled request unchanged.
      offer = 1'b1;
    end else if (!rst) begin
      // Consume markers at the head; a drain marker blocks until the
      // block has delivered every expected byte.
      while (pending_bytes.size() > 0 && pending_bytes[0].kind != ITEM_BYTE &&
             !(pending_bytes[0].kind == ITEM_DRAIN && expected_frame_bytes.size() != 0)) begin
        case (pending_bytes[0].kind)
          ITEM_RX_HOLD: rx_hold_requests <= rx_hold_requests + 1;
          ITEM_CALM:    calm_tail <= 1'b1;
          default:      ;
        endcase
        void'(pending_bytes.pop_front());
      end
      if (send_seg == 0) begin
        send_seg = $urandom_range(20, 80);
        send_busy = ($urandom_range(0, 2) != 0);
      end else begin
        send_seg--;
      end
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_bytes.size() > 0 && pending_bytes[0].kind == ITEM_BYTE) begin
        if (!calm_tail && send_busy && $urandom_range(0, 5) == 0) begin
          // Start an idle burst that begins with this cycle.
          send_gap = $urandom_range(0, 5);
        end else begin
          offer = 1'b1;
          data_byte <= pending_bytes[0].value;
        end
      end
    end
    in_valid <= offer;
  end

  // Receiver: random stall bursts, plus one long hold on request so the
  // request queue inside the block fills and the input stalls.
  always @(negedge clk) begin : receiver
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_holds_served != rx_hold_requests) begin
      rx_holds_served++;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      if (recv_seg == 0) begin
        recv_seg = $urandom_range(20, 80);
        recv_busy = ($urandom_range(0, 2) != 0);
      end else begin
        recv_seg--;
      end
      if (!calm_tail && recv_busy && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Checker: compare each delivered frame byte with the oldest expectation.
  always @(posedge clk) begin : monitor
    frame_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_frame_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected frame byte %02h first=%0b last=%0b",
                                  frame_byte, frame_first, frame_last));
      end else begin
        want = expected_frame_bytes.pop_front();
        if (frame_byte !== want.value) begin
          report_mismatch($sformatf("frame_byte %02h, want %02h", frame_byte, want.value));
        end
        if (frame_first !== want.first) begin
          report_mismatch($sformatf("frame_first %b, want %b on byte %02h",
                                    frame_first, want.first, want.value));
        end
        if (frame_last !== want.last) begin
          report_mismatch($sformatf("frame_last %b, want %b on byte %02h",
                                    frame_last, want.last, want.value));
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int   counted;
    int   mark;
    int   pick;
    logic [7:0] b;
    bit   hold_placed;
    bit   drain_placed;
    bit   calm_placed;

    hold_placed  = 1'b0;
    drain_placed = 1'b0;
    calm_placed  = 1'b0;
    counted = 0;

    // Directed: extreme noise bytes, dropped.
    push_byte(8'h00);
    push_byte(8'hFF);
    // Zero length header: dropped, hunting resumes right after it.
    push_byte(SYNC_BYTE);
    push_byte(SECOND_MASK);
    push_byte(8'h00);
    // Bad second byte, top bits 110 and 011.
    push_byte(SYNC_BYTE);
    push_byte(8'hC0);
    push_byte(SYNC_BYTE);
    push_byte(8'h7F);
    // Repeated sync byte, then a one-byte frame carrying a sync byte.
    push_byte(SYNC_BYTE);
    push_byte(SYNC_BYTE);
    push_byte(SECOND_MASK);
    push_byte(8'h01);
    push_byte(SYNC_BYTE);
    // Back-to-back frame with extreme payload bytes.
    push_byte(SYNC_BYTE);
    push_byte(SECOND_MASK);
    push_byte(8'h02);
    push_byte(8'hFF);
    push_byte(8'h00);

    // Random part: mostly well-formed frames, some noise and broken headers.
    while (counted < RANDOM_ITEMS) begin
      mark = pending_bytes.size();
      if (!hold_placed && counted >= 100) begin
        // Stall the receiver for a long stretch while a frame streams in.
        push_marker(ITEM_RX_HOLD);
        push_frame(13'd30, 1'b0);
        hold_placed = 1'b1;
      end
      if (!drain_placed && counted >= 280) begin
        push_marker(ITEM_DRAIN);
        drain_placed = 1'b1;
      end
      if (!calm_placed && counted >= 380) begin
        push_marker(ITEM_CALM);
        calm_placed = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // Noise outside frames; keep sync bytes out of it.
        repeat ($urandom_range(1, 3)) begin
          b = 8'($urandom_range(0, 255));
          if (b == SYNC_BYTE) b = b + 8'h01;
          push_byte(b);
        end
      end else if (pick == 1) begin
        // Sync byte followed by a bad or repeated second byte.
        push_byte(SYNC_BYTE);
        do b = 8'($urandom_range(0, 255)); while ((b & SECOND_MASK) == SECOND_MASK);
        push_byte(b);
      end else if (pick == 2) begin
        push_byte(SYNC_BYTE);
        push_byte(SECOND_MASK);
        push_byte(8'h00);
      end else if ($urandom_range(0, 29) == 0) begin
        push_frame(13'($urandom_range(256, 300)), pick == 3);
      end else begin
        push_frame(13'($urandom_range(1, 24)), pick == 3);
      end
      counted += pending_bytes.size() - mark;
    end

    // Release reset on a falling edge.
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Wait for the last request to be taken, then for the last frame byte.
    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_frame_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
